@@ rtl/tbd_pkg.sv @@
// shared types, codes and constants for the tape block deframer
package tbd_pkg;

   localparam int SYNC_LENGTH_DEFAULT = 5;
   localparam int POS_W = 3;
   localparam int HEADER_LENGTH = 5;
   localparam logic [POS_W-1:0] HEADER_LAST = POS_W'(HEADER_LENGTH - 1);

   localparam logic [7:0] ERROR_BYTE = 8'h69;
   localparam logic [7:0] ERROR_SUM = 8'hFF;
   localparam logic [15:0] END_WRAP = 16'hFFFF;

   // sync pattern repeats every five bytes for long sync runs
   localparam logic [7:0] SYNC_PATTERN [8] = '{
      8'h65, 8'h69, 8'h6C, 8'h79, 8'h4B, 8'h65, 8'h69, 8'h6C
   };

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2,
      PH_CHECK  = 2'd3
   } phase_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_error;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  data_value;
      logic [7:0]  block_id;
      logic [15:0] load_address;
      logic [15:0] last_address;
      logic [7:0]  sum_computed;
      logic [7:0]  sum_read;
      logic [16:0] error_count;
      logic        sum_ok;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } result_type;

   function automatic logic [15:0] last_of(input logic [15:0] end_addr);
      return (end_addr == 16'd0) ? END_WRAP : end_addr - 16'd1;
   endfunction

endpackage

@@ rtl/tbd_frame.sv @@
// framing state machine: sync hunt, header capture, data and check byte
module tbd_frame import tbd_pkg::*; #(
   parameter int SYNC_LENGTH = SYNC_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req,
   output result_type result
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [7:0]       header_ff [HEADER_LENGTH];
   logic [16:0]      bytes_left_ff, bytes_left_in;
   logic [15:0]      next_address_ff, next_address_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [16:0]      errors_seen_ff, errors_seen_in;

   logic             header_write;
   logic [POS_W:0]   pos_cand;
   logic [15:0]      load_addr, last_addr, stored_last;
   logic [7:0]       check_read;
   logic [16:0]      check_errors;

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      bytes_left_in   = bytes_left_ff;
      next_address_in = next_address_ff;
      running_sum_in  = running_sum_ff;
      errors_seen_in  = errors_seen_ff;
      header_write    = 1'b0;
      result          = '0;
      pos_cand        = '0;
      load_addr       = {header_ff[2], header_ff[1]};
      last_addr       = last_of({req.data_byte, header_ff[3]});
      stored_last     = last_of({header_ff[4], header_ff[3]});
      check_read      = req.byte_error ? ERROR_SUM : req.data_byte;
      check_errors    = errors_seen_ff + 17'(req.byte_error);
      case (phase_ff)
         PH_HUNT: begin
            if (!req.byte_error && req.data_byte == SYNC_PATTERN[position_ff]) begin
               pos_cand = {1'b0, position_ff} + 1'b1;
            end else if (!req.byte_error && req.data_byte == SYNC_PATTERN[0]) begin
               // mismatching byte restarts the sync as its first byte
               pos_cand = (POS_W+1)'(1);
            end
            if (pos_cand >= (POS_W+1)'(SYNC_LENGTH)) begin
               phase_in    = PH_HEADER;
               position_in = '0;
            end else begin
               position_in = pos_cand[POS_W-1:0];
            end
         end
         PH_HEADER: begin
            if (req.byte_error) begin
               phase_in    = PH_HUNT;
               position_in = '0;
            end else begin
               header_write = 1'b1;
               position_in  = position_ff + 1'b1;
               if (position_ff == HEADER_LAST) begin
                  position_in = '0;
                  if (last_addr < load_addr) begin
                     phase_in                 = PH_HUNT;
                     result.valid             = 1'b1;
                     result.item.kind         = KIND_REJECT;
                     result.item.block_id     = header_ff[0];
                     result.item.load_address = load_addr;
                     result.item.last_address = last_addr;
                  end else begin
                     phase_in        = PH_DATA;
                     bytes_left_in   = {1'b0, last_addr} - {1'b0, load_addr} + 17'd1;
                     next_address_in = load_addr;
                     running_sum_in  = '0;
                     errors_seen_in  = '0;
                  end
               end
            end
         end
         PH_DATA: begin
            result.valid           = 1'b1;
            result.item.kind       = KIND_DATA;
            result.item.address    = next_address_ff;
            result.item.data_value = req.byte_error ? ERROR_BYTE : req.data_byte;
            running_sum_in  = running_sum_ff + (req.byte_error ? ERROR_SUM : req.data_byte);
            errors_seen_in  = check_errors;
            next_address_in = next_address_ff + 16'd1;
            bytes_left_in   = bytes_left_ff - 17'd1;
            if (bytes_left_ff == 17'd1) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            errors_seen_in           = check_errors;
            result.valid             = 1'b1;
            result.item.kind         = KIND_REPORT;
            result.item.block_id     = header_ff[0];
            result.item.load_address = load_addr;
            result.item.last_address = stored_last;
            result.item.sum_computed = running_sum_ff;
            result.item.sum_read     = check_read;
            result.item.error_count  = check_errors;
            result.item.sum_ok       = (running_sum_ff == check_read);
            phase_in    = PH_HUNT;
            position_in = '0;
         end
         default: begin
            phase_in    = PH_HUNT;
            position_in = '0;
         end
      endcase
      result.valid = result.valid & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         position_ff     <= '0;
         bytes_left_ff   <= '0;
         next_address_ff <= '0;
         running_sum_ff  <= '0;
         errors_seen_ff  <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         bytes_left_ff   <= bytes_left_in;
         next_address_ff <= next_address_in;
         running_sum_ff  <= running_sum_in;
         errors_seen_ff  <= errors_seen_in;
      end
   end

   // header bytes need no reset, they are always written before use
   always_ff @(posedge clock) begin
      if (accept && header_write) begin
         for (int i = 0; i < HEADER_LENGTH; i++) begin
            if (position_ff == POS_W'(i)) begin
               header_ff[i] <= req.data_byte;
            end
         end
      end
   end

endmodule

@@ rtl/tbd_skid.sv @@
// output register with one skid entry
module tbd_skid import tbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_item,
   output logic       full
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_item_ff, out_item_in;
   rsp_type skid_item_ff, skid_item_in;
   logic    taken;

   always_comb begin
      taken         = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff && !taken;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (taken && skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_item_in   = skid_item_ff;
         skid_valid_in = 1'b0;
      end
      // a new item only arrives while the skid entry is empty
      if (result.valid) begin
         if (!out_valid_ff || taken) begin
            out_valid_in = 1'b1;
            out_item_in  = result.item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = result.item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;
   assign full      = skid_valid_ff;

endmodule

@@ rtl/tape_block_deframer.sv @@
// tape block deframer top level
// a result item is registered in the output register, or in its skid entry while the output is stalled
// throughput: one input item per cycle while req_stall is low; the framing state updates as each item is accepted
// req_stall rises only while the output register and its skid entry are both full
// reset: synchronous, active high; returns to sync hunt with counters cleared
// header bytes are not reset, they are always captured before they are reported
module tape_block_deframer import tbd_pkg::*; #(
   parameter int SYNC_LENGTH = SYNC_LENGTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic       accept;
   result_type result;

   assign accept = req_valid && !req_stall;

   tbd_frame #(
      .SYNC_LENGTH(SYNC_LENGTH)
   ) u_frame (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_item),
      .result(result)
   );

   tbd_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .full     (req_stall)
   );

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry full while output register empty");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.kind == KIND_DATA || rsp_item.kind == KIND_REPORT ||
                     rsp_item.kind == KIND_REJECT))
      else $error("result item with unused kind code");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind != KIND_DATA |->
         rsp_item.address == 16'd0 && rsp_item.data_value == 8'd0)
      else $error("frame item carries data byte fields");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.kind == KIND_DATA |->
         rsp_item.block_id == 8'd0 && rsp_item.error_count == 17'd0 && !rsp_item.sum_ok)
      else $error("data item carries frame fields");
`endif

endmodule

@@ tb/tape_block_deframer_tb.sv @@
// testbench for the tape block deframer: random framed byte streams checked against a predictor
`timescale 1ns / 100ps

module tape_block_deframer_tb import tbd_pkg::*;;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam int HOLD_AFTER  = 300;
   localparam int ITEM_TARGET = 950;

   // ways to finish a frame's check byte
   localparam int CHECK_GOOD    = 0;
   localparam int CHECK_WRONG   = 1;
   localparam int CHECK_ERRORED = 2;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   req_type byte_stream [$];
   rsp_type due_outputs [$];
   int      items_total;
   int      items_in = 0;
   int      mismatches = 0;
   int      idle_cycles = 0;

   // predictor state
   phase_type   frame_phase = PH_HUNT;
   int          sync_pos = 0;
   logic [7:0]  hdr [HEADER_LENGTH];
   logic [7:0]  frame_id;
   logic [15:0] frame_load;
   logic [15:0] frame_last;
   logic [16:0] bytes_to_go;
   logic [15:0] next_addr;
   logic [7:0]  run_sum;
   logic [16:0] err_total;

   // sender and receiver pacing
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   tape_block_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   task automatic deframe_byte(input req_type it);
      rsp_type     r;
      logic [15:0] end_addr;
      logic [7:0]  rd;
      r = '0;
      case (frame_phase)
         PH_HUNT: begin
            if (!it.byte_error && it.data_byte == SYNC_PATTERN[sync_pos % 5]) begin
               sync_pos++;
            end else begin
               // a mismatching byte may still open a new sync run
               sync_pos = (!it.byte_error && it.data_byte == SYNC_PATTERN[0]) ? 1 : 0;
            end
            if (sync_pos >= SYNC_LENGTH_DEFAULT) begin
               frame_phase = PH_HEADER;
               sync_pos = 0;
            end
         end
         PH_HEADER: begin
            if (it.byte_error) begin
               frame_phase = PH_HUNT;
               sync_pos = 0;
            end else begin
               hdr[sync_pos] = it.data_byte;
               sync_pos++;
               if (sync_pos == HEADER_LENGTH) begin
                  sync_pos = 0;
                  frame_id = hdr[0];
                  frame_load = {hdr[2], hdr[1]};
                  end_addr = {hdr[4], hdr[3]};
                  frame_last = (end_addr == 16'd0) ? END_WRAP : end_addr - 16'd1;
                  if (frame_last < frame_load) begin
                     frame_phase = PH_HUNT;
                     r.kind = KIND_REJECT;
                     r.block_id = frame_id;
                     r.load_address = frame_load;
                     r.last_address = frame_last;
                     due_outputs.push_back(r);
                  end else begin
                     bytes_to_go = 17'(frame_last - frame_load) + 17'd1;
                     next_addr = frame_load;
                     run_sum = 8'd0;
                     err_total = 17'd0;
                     frame_phase = PH_DATA;
                  end
               end
            end
         end
         PH_DATA: begin
            r.kind = KIND_DATA;
            r.address = next_addr;
            r.data_value = it.byte_error ? ERROR_BYTE : it.data_byte;
            run_sum = run_sum + (it.byte_error ? ERROR_SUM : it.data_byte);
            if (it.byte_error) err_total = err_total + 17'd1;
            next_addr = next_addr + 16'd1;
            bytes_to_go = bytes_to_go - 17'd1;
            if (bytes_to_go == 17'd0) frame_phase = PH_CHECK;
            due_outputs.push_back(r);
         end
         default: begin
            rd = it.byte_error ? ERROR_SUM : it.data_byte;
            if (it.byte_error) err_total = err_total + 17'd1;
            r.kind = KIND_REPORT;
            r.block_id = frame_id;
            r.load_address = frame_load;
            r.last_address = frame_last;
            r.sum_computed = run_sum;
            r.sum_read = rd;
            r.error_count = err_total;
            r.sum_ok = (run_sum == rd);
            frame_phase = PH_HUNT;
            sync_pos = 0;
            due_outputs.push_back(r);
         end
      endcase
   endtask

   task automatic check_field(input string label, input logic [16:0] want,
                              input logic [16:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   task automatic add_byte(input logic [7:0] b, input logic e);
      req_type it;
      it.data_byte = b;
      it.byte_error = e;
      byte_stream.push_back(it);
   endtask

   task automatic add_sync();
      for (int i = 0; i < SYNC_LENGTH_DEFAULT; i++) add_byte(SYNC_PATTERN[i % 5], 1'b0);
   endtask

   // header, then data and check byte when the header is accepted
   task automatic add_frame(input logic [7:0] id, input logic [15:0] load,
                            input logic [15:0] end_addr, input int err_pct,
                            input int check_mode);
      logic [15:0] last;
      logic [7:0]  sum;
      logic [7:0]  b;
      logic        e;
      int          n;
      add_byte(id, 1'b0);
      add_byte(load[7:0], 1'b0);
      add_byte(load[15:8], 1'b0);
      add_byte(end_addr[7:0], 1'b0);
      add_byte(end_addr[15:8], 1'b0);
      last = (end_addr == 16'd0) ? END_WRAP : end_addr - 16'd1;
      if (last >= load) begin
         n = int'(last) - int'(load) + 1;
         sum = 8'd0;
         for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            e = ($urandom_range(0, 99) < err_pct);
            sum = sum + (e ? ERROR_SUM : b);
            add_byte(b, e);
         end
         case (check_mode)
            CHECK_GOOD:    add_byte(sum, 1'b0);
            CHECK_WRONG:   add_byte(8'($urandom_range(0, 255)), 1'b0);
            default:       add_byte(8'($urandom_range(0, 255)), 1'b1);
         endcase
      end
   endtask

   // driver: bursts of items with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         frame_phase = PH_HUNT;
         sync_pos = 0;
         bytes_to_go = 17'd0;
         next_addr = 16'd0;
         run_sum = 8'd0;
         err_total = 17'd0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_item);
            items_in++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
               req_valid <= 1'b1;
               req_item <= byte_stream.pop_front();
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && items_in >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         rsp_stall <= ($urandom_range(0, 3) < stall_mode);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_outputs.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual %p", $time, rsp_item);
            mismatches++;
         end else begin
            want = due_outputs.pop_front();
            check_field("kind", 17'(want.kind), 17'(rsp_item.kind));
            check_field("address", 17'(want.address), 17'(rsp_item.address));
            check_field("data_value", 17'(want.data_value), 17'(rsp_item.data_value));
            check_field("block_id", 17'(want.block_id), 17'(rsp_item.block_id));
            check_field("load_address", 17'(want.load_address), 17'(rsp_item.load_address));
            check_field("last_address", 17'(want.last_address), 17'(rsp_item.last_address));
            check_field("sum_computed", 17'(want.sum_computed), 17'(rsp_item.sum_computed));
            check_field("sum_read", 17'(want.sum_read), 17'(rsp_item.sum_read));
            check_field("error_count", want.error_count, rsp_item.error_count);
            check_field("sum_ok", 17'(want.sum_ok), 17'(rsp_item.sum_ok));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int          pick;
      int          n;
      int          k;
      logic [15:0] load;
      logic [15:0] end_addr;
      logic [7:0]  b;

      // sync restarted by a mismatch that is itself a first sync byte
      add_byte(SYNC_PATTERN[0], 1'b0);
      add_byte(SYNC_PATTERN[1], 1'b0);
      add_sync();
      // one byte at the top of memory, errored data and errored check byte
      add_frame(8'hFF, 16'hFFFF, 16'h0000, 100, CHECK_ERRORED);
      // errored sync byte, then a header with end equal to load
      add_byte(SYNC_PATTERN[0], 1'b0);
      add_byte(SYNC_PATTERN[1], 1'b0);
      add_byte(SYNC_PATTERN[2], 1'b1);
      add_sync();
      add_frame(8'h00, 16'h0010, 16'h0010, 0, CHECK_GOOD);

      while (byte_stream.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end
         end else if (pick < 16) begin
            // sync broken by a wrong or errored byte
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) add_byte(SYNC_PATTERN[i], 1'b0);
            if ($urandom_range(0, 1) == 0) begin
               add_byte(SYNC_PATTERN[k], 1'b1);
            end else begin
               b = 8'($urandom_range(0, 255));
               if (b == SYNC_PATTERN[k]) b = b ^ 8'h01;
               add_byte(b, 1'b0);
            end
         end else if (pick < 24) begin
            // header dropped on an errored byte
            add_sync();
            k = $urandom_range(0, HEADER_LENGTH - 1);
            for (int i = 0; i < k; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            add_sync();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // last address below load address
               load = 16'($urandom_range(1, 65535));
               end_addr = 16'($urandom_range(1, int'(load)));
            end else if (pick < 25) begin
               // block runs to the top of memory, end read as zero
               n = $urandom_range(1, 12);
               load = 16'(65536 - n);
               end_addr = 16'd0;
            end else begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
               load = 16'($urandom_range(0, 65535 - n));
               end_addr = load + 16'(n);
            end
            k = $urandom_range(0, 9);
            add_frame(8'($urandom_range(0, 255)), load, end_addr,
                      ($urandom_range(0, 2) == 0) ? 10 : 0,
                      (k == 0) ? CHECK_ERRORED : (k == 1) ? CHECK_WRONG : CHECK_GOOD);
         end
      end
      items_total = byte_stream.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (items_in != items_total || due_outputs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ tape_block_deframer.f @@
rtl/tbd_pkg.sv
rtl/tbd_frame.sv
rtl/tbd_skid.sv
rtl/tape_block_deframer.sv
tb/tape_block_deframer_tb.sv
